FILE: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
package ffba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 17;

    localparam logic [ADDR_W-1:0] HEADER_BYTES   = 17'd24;
    localparam logic [ADDR_W-1:0] POOL_MAX_BYTES = 17'd65536;
    localparam logic [CNT_W-1:0]  FULL_COUNT     = CNT_W'(MAX_BLOCKS);

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_RESIZE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic              free;
    } entry_t;

    typedef struct packed {
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] address;
        logic [1:0]        operation;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
    } rsp_t;

    function automatic logic [ADDR_W-1:0] strip_header(input logic [ADDR_W-1:0] s);
        strip_header = (s >= HEADER_BYTES) ? s - HEADER_BYTES : s;
    endfunction

endpackage

FILE: rtl/ffba_core.sv
`timescale 1ns / 1ps
module ffba_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  ffba_pkg::cmd_t cmd,
    input  logic          cfg_we,
    input  logic [16:0]   cfg_pool,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffba_pkg::rsp_t rsp
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_AW1, S_AW2, S_RDPREV, S_CHKPREV,
        S_RDNEXT, S_CHKNEXT, S_MERGE, S_FIN
    } state_t;

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic we;
    logic [IDX_W-1:0] wa;
    entry_t wd;

    state_t state_reg, state_next;
    logic init_reg, init_next;
    logic [ADDR_W-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0] op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] vidx_reg, vidx_next;
    logic vld_reg, vld_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    entry_t ent_reg, ent_next;
    logic [ADDR_W-1:0] pstart_reg, pstart_next;
    logic [ADDR_W-1:0] acc_reg, acc_next;
    logic prev_free_reg, prev_free_next;
    logic next_free_reg, next_free_next;
    logic up_reg, up_next;
    logic [1:0] dist_reg, dist_next;
    logic alloc_reg, alloc_next;
    logic second_reg, second_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [1:0] st_reg, st_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_reg      <= 1'b1;
            pool_reg      <= POOL_MAX_BYTES;
            count_reg     <= CNT_W'(1);
            op_reg        <= OP_ALLOC;
            addr_reg      <= '0;
            size_reg      <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            vidx_reg      <= '0;
            vld_reg       <= 1'b0;
            idx_reg       <= '0;
            ent_reg       <= '0;
            pstart_reg    <= '0;
            acc_reg       <= '0;
            prev_free_reg <= 1'b0;
            next_free_reg <= 1'b0;
            up_reg        <= 1'b0;
            dist_reg      <= '0;
            alloc_reg     <= 1'b0;
            second_reg    <= 1'b0;
            res_reg       <= '0;
            st_reg        <= STAT_OK;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            pool_reg      <= pool_next;
            count_reg     <= count_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            size_reg      <= size_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            vidx_reg      <= vidx_next;
            vld_reg       <= vld_next;
            idx_reg       <= idx_next;
            ent_reg       <= ent_next;
            pstart_reg    <= pstart_next;
            acc_reg       <= acc_next;
            prev_free_reg <= prev_free_next;
            next_free_reg <= next_free_next;
            up_reg        <= up_next;
            dist_reg      <= dist_next;
            alloc_reg     <= alloc_next;
            second_reg    <= second_next;
            res_reg       <= res_next;
            st_reg        <= st_next;
        end
    end

    always_comb
    begin
        entry_t e;
        logic fit;
        logic split;
        logic [CNT_W-1:0] k;
        logic [CNT_W-1:0] d;
        logic [CNT_W-1:0] last;

        state_next     = state_reg;
        init_next      = init_reg;
        pool_next      = pool_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        vidx_next      = ptr_reg;
        vld_next       = 1'b0;
        idx_next       = idx_reg;
        ent_next       = ent_reg;
        pstart_next    = pstart_reg;
        acc_next       = acc_reg;
        prev_free_next = prev_free_reg;
        next_free_next = next_free_reg;
        up_next        = up_reg;
        dist_next      = dist_reg;
        alloc_next     = alloc_reg;
        second_next    = second_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        we             = 1'b0;
        wa             = '0;
        wd             = '0;
        rd_addr        = ptr_reg[IDX_W-1:0];
        e              = rd_data_reg;
        fit            = 1'b0;
        split          = 1'b0;
        k              = '0;
        d              = '0;
        last           = count_reg - CNT_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (init_reg)
                begin
                    we         = 1'b1;
                    wa         = '0;
                    wd.start   = '0;
                    wd.len     = pool_reg;
                    wd.free    = 1'b1;
                    count_next = CNT_W'(1);
                    init_next  = 1'b0;
                end
                else if (cmd_valid)
                begin
                    op_next     = cmd.operation;
                    addr_next   = cmd.address;
                    size_next   = cmd.size;
                    second_next = 1'b0;
                    res_next    = '0;
                    st_next     = STAT_OK;
                    ptr_next    = '0;
                    case (cmd.operation)
                        OP_ALLOC:
                        begin
                            size_next  = strip_header(cmd.size);
                            alloc_next = 1'b1;
                            state_next = S_SCAN;
                        end
                        OP_FREE:
                        begin
                            alloc_next = 1'b0;
                            state_next = (cmd.address == '0) ? S_FIN : S_SCAN;
                        end
                        OP_RESIZE:
                        begin
                            if (cmd.address == '0)
                            begin
                                size_next  = strip_header(cmd.size);
                                alloc_next = 1'b1;
                            end
                            else
                            begin
                                alloc_next = 1'b0;
                            end
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (ptr_reg < count_reg)
                begin
                    vld_next = 1'b1;
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (vld_reg)
                begin
                    if (alloc_reg)
                    begin
                        fit   = e.free && (e.len >= size_reg);
                        split = {1'b0, e.len} >= ({1'b0, size_reg} + {1'b0, HEADER_BYTES});
                        if (fit)
                        begin
                            vld_next = 1'b0;
                            idx_next = vidx_reg;
                            ent_next = e;
                            if (split && count_reg == FULL_COUNT)
                            begin
                                st_next    = STAT_FULL;
                                res_next   = '0;
                                state_next = S_FIN;
                            end
                            else if (split)
                            begin
                                if (count_reg > vidx_reg + CNT_W'(1))
                                begin
                                    up_next    = 1'b1;
                                    ptr_next   = last;
                                    cnt_next   = last - vidx_reg;
                                    state_next = S_SHIFT;
                                end
                                else
                                begin
                                    state_next = S_AW1;
                                end
                            end
                            else
                            begin
                                we       = 1'b1;
                                wa       = vidx_reg[IDX_W-1:0];
                                wd.start = e.start;
                                wd.len   = e.len;
                                wd.free  = 1'b0;
                                res_next = e.start + HEADER_BYTES;
                                st_next  = STAT_OK;
                                if (op_reg == OP_RESIZE && addr_reg != '0)
                                begin
                                    second_next = 1'b1;
                                    alloc_next  = 1'b0;
                                    ptr_next    = '0;
                                    state_next  = S_SCAN;
                                end
                                else
                                begin
                                    state_next = S_FIN;
                                end
                            end
                        end
                        else if (vidx_reg == last)
                        begin
                            vld_next   = 1'b0;
                            st_next    = STAT_NOFIT;
                            res_next   = '0;
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        if ({1'b0, e.start} + {1'b0, HEADER_BYTES} == {1'b0, addr_reg})
                        begin
                            vld_next = 1'b0;
                            idx_next = vidx_reg;
                            ent_next = e;
                            acc_next = e.len;
                            if (op_reg == OP_FREE || second_reg)
                            begin
                                state_next = S_RDPREV;
                            end
                            else if (e.len >= size_reg)
                            begin
                                res_next   = addr_reg;
                                st_next    = STAT_OK;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                size_next  = strip_header(size_reg);
                                alloc_next = 1'b1;
                                ptr_next   = '0;
                            end
                        end
                        else if (vidx_reg == last)
                        begin
                            vld_next = 1'b0;
                            if (!second_reg)
                            begin
                                st_next  = STAT_UNKNOWN;
                                res_next = '0;
                            end
                            state_next = S_FIN;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                if (cnt_reg != '0)
                begin
                    rd_addr  = ptr_reg[IDX_W-1:0];
                    vld_next = 1'b1;
                    cnt_next = cnt_reg - CNT_W'(1);
                    ptr_next = up_reg ? ptr_reg - CNT_W'(1) : ptr_reg + CNT_W'(1);
                end
                if (vld_reg)
                begin
                    we = 1'b1;
                    if (up_reg)
                    begin
                        wa = IDX_W'(vidx_reg + CNT_W'(1));
                    end
                    else
                    begin
                        wa = IDX_W'(vidx_reg - CNT_W'(dist_reg));
                    end
                    wd = rd_data_reg;
                    if (cnt_reg == '0)
                    begin
                        state_next = up_reg ? S_AW1 : S_FIN;
                    end
                end
            end

            S_AW1:
            begin
                we         = 1'b1;
                wa         = IDX_W'(idx_reg + CNT_W'(1));
                wd.start   = ent_reg.start + HEADER_BYTES + size_reg;
                wd.len     = ent_reg.len - size_reg - HEADER_BYTES;
                wd.free    = 1'b1;
                state_next = S_AW2;
            end

            S_AW2:
            begin
                we         = 1'b1;
                wa         = idx_reg[IDX_W-1:0];
                wd.start   = ent_reg.start;
                wd.len     = size_reg;
                wd.free    = 1'b0;
                count_next = count_reg + CNT_W'(1);
                res_next   = ent_reg.start + HEADER_BYTES;
                st_next    = STAT_OK;
                if (op_reg == OP_RESIZE && addr_reg != '0)
                begin
                    second_next = 1'b1;
                    alloc_next  = 1'b0;
                    ptr_next    = '0;
                    state_next  = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_RDPREV:
            begin
                if (idx_reg == '0)
                begin
                    prev_free_next = 1'b0;
                    state_next     = S_RDNEXT;
                end
                else
                begin
                    rd_addr    = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = S_CHKPREV;
                end
            end

            S_CHKPREV:
            begin
                prev_free_next = e.free;
                if (e.free)
                begin
                    acc_next    = acc_reg + e.len + HEADER_BYTES;
                    pstart_next = e.start;
                end
                state_next = S_RDNEXT;
            end

            S_RDNEXT:
            begin
                if (idx_reg + CNT_W'(1) >= count_reg)
                begin
                    next_free_next = 1'b0;
                    state_next     = S_MERGE;
                end
                else
                begin
                    rd_addr    = IDX_W'(idx_reg + CNT_W'(1));
                    state_next = S_CHKNEXT;
                end
            end

            S_CHKNEXT:
            begin
                next_free_next = e.free;
                if (e.free)
                begin
                    acc_next = acc_reg + e.len + HEADER_BYTES;
                end
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                we = 1'b1;
                if (prev_free_reg)
                begin
                    wa       = IDX_W'(idx_reg - CNT_W'(1));
                    wd.start = pstart_reg;
                    wd.len   = acc_reg;
                    wd.free  = 1'b1;
                    k        = idx_reg;
                    d        = next_free_reg ? CNT_W'(2) : CNT_W'(1);
                end
                else if (next_free_reg)
                begin
                    wa       = idx_reg[IDX_W-1:0];
                    wd.start = ent_reg.start;
                    wd.len   = acc_reg;
                    wd.free  = 1'b1;
                    k        = idx_reg + CNT_W'(1);
                    d        = CNT_W'(1);
                end
                else
                begin
                    wa       = idx_reg[IDX_W-1:0];
                    wd.start = ent_reg.start;
                    wd.len   = ent_reg.len;
                    wd.free  = 1'b1;
                end
                count_next = count_reg - d;
                dist_next  = d[1:0];
                up_next    = 1'b0;
                if (d != '0 && count_reg > k + d)
                begin
                    ptr_next   = k + d;
                    cnt_next   = count_reg - (k + d);
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            pool_next = (cfg_pool > POOL_MAX_BYTES) ? POOL_MAX_BYTES : cfg_pool;
            init_next = 1'b1;
        end
    end

    assign cmd_ready          = (state_reg == S_IDLE) && !init_reg;
    assign rsp_valid          = (state_reg == S_FIN);
    assign rsp.result_address = res_reg;
    assign rsp.status         = st_reg;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// Allocate scans the block table and, on a split, moves the later entries up and writes both halves;
// free scans the table, reads both neighbours and merges, shifting later entries down when merging;
// resize takes up to about three passes over the block table.
// Throughput: one transaction at a time; each pass reads one table entry per cycle.
// Reset, or a cfg_wdata write, restores one free block.
`timescale 1ns / 1ps
module first_fit_block_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], address[18:2], size[35:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_address[16:0], status[18:17]
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);
    import ffba_pkg::*;

    cmd_t cmd;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_ready;
    logic m_tvalid_reg, m_tvalid_next;
    rsp_t m_data_reg, m_data_next;

    assign cmd = s_tdata[35:0];

    ffba_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_pool  (cfg_wdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (rsp_valid && rsp_ready)
        begin
            m_tvalid_next = 1'b1;
            m_data_next   = rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

endmodule

FILE: tb/sv/ffba_checker.sv
`timescale 1ns / 1ps
module ffba_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    output int          mismatches,
    output int          outstanding
);
    import ffba_pkg::*;

    localparam int HDR = 24;

    logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_len   [MAX_BLOCKS];
    logic              blk_free  [MAX_BLOCKS];
    int                blk_count;
    rsp_t              expected_rsp_q[$];

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic reinit_pool(input logic [16:0] bytes);
        logic [ADDR_W-1:0] b;
        b = (bytes > POOL_MAX_BYTES) ? POOL_MAX_BYTES : bytes;
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            blk_start[k] = '0;
            blk_len[k]   = '0;
            blk_free[k]  = 1'b0;
        end
        blk_len[0]  = b;
        blk_free[0] = 1'b1;
        blk_count   = 1;
    endtask

    function automatic int find_payload(input logic [ADDR_W-1:0] addr);
        for (int k = 0; k < blk_count; k++)
            if (int'(blk_start[k]) + HDR == int'(addr))
                return k;
        return -1;
    endfunction

    task automatic grant_first_fit(input int req, output logic [ADDR_W-1:0] res,
                                   output logic [1:0] st);
        res = '0;
        st  = STAT_NOFIT;
        if (req >= HDR)
            req -= HDR;
        for (int k = 0; k < blk_count; k++)
        begin
            if (!blk_free[k] || int'(blk_len[k]) < req)
                continue;
            if (int'(blk_len[k]) >= req + HDR)
            begin
                if (blk_count >= MAX_BLOCKS)
                begin
                    st = STAT_FULL;
                    return;
                end
                for (int j = blk_count; j > k + 1; j--)
                begin
                    blk_start[j] = blk_start[j-1];
                    blk_len[j]   = blk_len[j-1];
                    blk_free[j]  = blk_free[j-1];
                end
                blk_start[k+1] = ADDR_W'(int'(blk_start[k]) + HDR + req);
                blk_len[k+1]   = ADDR_W'(int'(blk_len[k]) - req - HDR);
                blk_free[k+1]  = 1'b1;
                blk_count++;
                blk_len[k] = ADDR_W'(req);
            end
            blk_free[k] = 1'b0;
            res = ADDR_W'(int'(blk_start[k]) + HDR);
            st  = STAT_OK;
            return;
        end
    endtask

    task automatic release_and_merge(input int idx);
        int k;
        blk_free[idx] = 1'b1;
        k = 0;
        while (k + 1 < blk_count)
        begin
            if (blk_free[k] && blk_free[k+1])
            begin
                blk_len[k] = ADDR_W'(int'(blk_len[k]) + HDR + int'(blk_len[k+1]));
                for (int j = k + 1; j + 1 < blk_count; j++)
                begin
                    blk_start[j] = blk_start[j+1];
                    blk_len[j]   = blk_len[j+1];
                    blk_free[j]  = blk_free[j+1];
                end
                blk_count--;
            end
            else
                k++;
        end
    endtask

    task automatic predict_request(input cmd_t c, output rsp_t r);
        int idx;
        r = '0;
        r.status = STAT_OK;
        case (c.operation)
            OP_ALLOC:
                grant_first_fit(int'(c.size), r.result_address, r.status);
            OP_FREE:
                if (c.address != '0)
                begin
                    idx = find_payload(c.address);
                    if (idx < 0)
                        r.status = STAT_UNKNOWN;
                    else
                        release_and_merge(idx);
                end
            OP_RESIZE:
                if (c.address == '0)
                    grant_first_fit(int'(c.size), r.result_address, r.status);
                else
                begin
                    idx = find_payload(c.address);
                    if (idx < 0)
                        r.status = STAT_UNKNOWN;
                    else if (blk_len[idx] >= c.size)
                        r.result_address = c.address;
                    else
                    begin
                        grant_first_fit(int'(c.size), r.result_address, r.status);
                        if (r.status == STAT_OK)
                        begin
                            idx = find_payload(c.address);
                            if (idx >= 0)
                                release_and_merge(idx);
                        end
                    end
                end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        rsp_t want, got;
        if (!rst_n)
        begin
            reinit_pool(17'd65536);
            expected_rsp_q.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                reinit_pool(cfg_wdata);
            if (s_tvalid && s_tready)
            begin
                c = s_tdata[35:0];
                predict_request(c, want);
                expected_rsp_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[18:0];
                if (expected_rsp_q.size() == 0)
                    report("unexpected transaction", int'(got), 0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (got.result_address != want.result_address)
                        report("result_address", got.result_address, want.result_address);
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                end
            end
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ffba_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 12000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [16:0] cfg_wdata;
    int          mismatches;
    int          outstanding;
    int          cycles;
    int          burst_left;
    int          stall_left;
    bit          stall_mode;
    logic [16:0] live_addr_q[$];

    first_fit_block_allocator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ffba_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // stretches of full readiness and of random stalls follow in random order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            stall_mode <= 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_left <= $urandom_range(20, 300);
                stall_mode <= 1'($urandom_range(0, 1));
            end
            else
                stall_left <= stall_left - 1;
            m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
            if (m_tvalid && m_tready && m_tdata[16:0] != '0)
                live_addr_q.push_back(m_tdata[16:0]);
        end
    end

    task automatic send(input logic [1:0] op, input logic [16:0] addr, input logic [16:0] sz);
        s_tdata  <= {4'b0, sz, addr, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_pool(input logic [16:0] bytes);
        drain();
        cfg_wdata <= bytes;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        live_addr_q.delete();
    endtask

    function automatic logic [16:0] pick_live();
        int k;
        logic [16:0] a;
        if (live_addr_q.size() == 0)
            return 17'($urandom_range(0, 200));
        k = $urandom_range(0, live_addr_q.size() - 1);
        a = live_addr_q[k];
        live_addr_q.delete(k);
        return a;
    endfunction

    function automatic logic [16:0] pick_size(input int cap);
        if ($urandom_range(0, 9) == 0)
            return 17'($urandom_range(0, 65536));
        return 17'($urandom_range(0, cap));
    endfunction

    task automatic random_items(input int n, input int cap);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send(OP_ALLOC, 17'($urandom_range(0, 131071)) & 17'h0, pick_size(cap));
            else if (r < 78)
                send(OP_FREE, pick_live(), 17'($urandom_range(0, 65536)));
            else if (r < 92)
                send(OP_RESIZE, pick_live(), pick_size(cap));
            else
                send(2'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)),
                     17'($urandom_range(0, 65536)));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        burst_left = 4;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        send(OP_ALLOC,  17'd0,      17'd0);
        send(OP_ALLOC,  17'd0,      17'd24);
        send(OP_ALLOC,  17'd0,      17'd23);
        send(OP_ALLOC,  17'd0,      17'd65536);
        send(OP_ALLOC,  17'h1FFFF,  17'd65535);
        send(OP_FREE,   17'd0,      17'd0);
        send(OP_FREE,   17'd5,      17'd0);
        send(OP_FREE,   17'h1FFFF,  17'h1FFFF);
        send(OP_RESIZE, 17'd0,      17'd40);
        send(OP_RESIZE, 17'd24,     17'd0);
        send(OP_RESIZE, 17'd48,     17'd300);
        send(OP_RESIZE, 17'd7,      17'd10);
        send(OP_RESIZE, 17'd72,     17'd65536);
        send(OP_FREE,   17'd24,     17'd0);
        send(OP_FREE,   17'd24,     17'd0);
        send(OP_UNUSED, 17'd96,     17'd100);
        send(OP_ALLOC,  17'd0,      17'd1);
        send(OP_FREE,   17'd72,     17'd0);

        random_items(380, 400);

        write_pool(17'd512);
        random_items(250, 120);

        // fill the table with small blocks, then punch holes
        write_pool(17'd65536);
        for (int k = 0; k < 262; k++)
            send(OP_ALLOC, 17'd0, 17'($urandom_range(0, 24)));
        random_items(80, 40);

        write_pool(17'd0);
        random_items(20, 30);
        write_pool(17'h1FFFF);
        random_items(300, 2000);
        write_pool(17'd1);
        random_items(20, 30);
        write_pool(17'd24);
        random_items(20, 50);
        write_pool(17'd48);
        random_items(20, 50);
        write_pool(17'($urandom_range(1000, 8000)));
        random_items(100, 600);

        drain();
        repeat (1100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: first_fit_block_allocator.f
rtl/ffba_pkg.sv
rtl/ffba_core.sv
rtl/first_fit_block_allocator.sv
tb/sv/ffba_checker.sv
tb/sv/tb_top.sv
